/* rtl/core/gbpm_pkg.sv */
// Shared types, constants and helpers of the grid ball presence match core.
package gbpm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int GRID_IDX_W = 8;
    localparam int GRID_CNT_W = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_BITS;
    localparam int PROD_W     = COORD_BITS + GRID_IDX_W;
    localparam int NOM_W      = PROD_W + 1;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int DIST_W     = 48;
    localparam int INDEX_W    = 10;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_OUTSIDE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS = 3'd0,
        CFG_GRID_COLS = 3'd1,
        CFG_START_X   = 3'd2,
        CFG_START_Y   = 3'd3,
        CFG_PITCH_X   = 3'd4,
        CFG_PITCH_Y   = 3'd5,
        CFG_MISS_DIST = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [GRID_IDX_W-1:0] grid_row;
        logic [GRID_IDX_W-1:0] grid_col;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [COORD_BITS-1:0] nominal_x;
        logic [COORD_BITS-1:0] nominal_y;
        logic                  ball_present;
        logic [DIST_W-1:0]     nearest_dist_sq;
        logic [INDEX_W-1:0]    nearest_index;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    clear;
        logic    latch;
        logic    mul;
        logic    add;
        logic    scan_start;
        logic    scan_step;
        logic    emit;
        logic    emit_query;
        t_status status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic outside;
        logic last_addr;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [NOM_W-1:0] v);
        logic [NOM_W-1:0] lim;
        lim = NOM_W'({COORD_BITS{1'b1}});
        return (v > lim) ? {COORD_BITS{1'b1}} : v[COORD_BITS-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] sat_dist(input logic [SQ_W:0] v);
        logic [SQ_W:0] lim;
        lim = (SQ_W + 1)'({DIST_W{1'b1}});
        return (v > lim) ? {DIST_W{1'b1}} : v[DIST_W-1:0];
    endfunction

endpackage

/* rtl/core/gbpm_req_if.sv */
// Request channel: valid/ready handshake with one command payload.
interface gbpm_req_if;
    import gbpm_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/gbpm_rsp_if.sv */
// Response channel: valid/ready handshake with one result payload.
interface gbpm_rsp_if;
    import gbpm_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/gbpm_ctrl.sv */
// Sequencer of the match core: request decode, nominal setup, scan and drain.
module gbpm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [1:0]          i_req_cmd,
    input  gbpm_pkg::t_dp_stat  i_stat,
    output logic                o_req_ready,
    output gbpm_pkg::t_dp_cmd   o_cmd
);
    import gbpm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && t_cmd_code'(i_req_cmd) == CMD_QUERY
                        && !i_stat.empty && !i_stat.outside) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_stat.last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy && i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.status = STAT_OK;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = i_stat.out_free;
                case (t_cmd_code'(i_req_cmd))
                    CMD_LOAD: begin
                        o_cmd.emit   = accept;
                        o_cmd.load   = accept && !i_stat.full;
                        o_cmd.status = i_stat.full ? STAT_FULL : STAT_OK;
                    end
                    CMD_CLEAR: begin
                        o_cmd.emit  = accept;
                        o_cmd.clear = accept;
                    end
                    CMD_QUERY: begin
                        if (i_stat.empty) begin
                            o_cmd.emit   = accept;
                            o_cmd.status = STAT_EMPTY;
                        end else if (i_stat.outside) begin
                            o_cmd.emit   = accept;
                            o_cmd.status = STAT_OUTSIDE;
                        end else begin
                            o_cmd.latch = accept;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MUL:  o_cmd.mul = 1'b1;
            ST_ADD: begin
                o_cmd.add        = 1'b1;
                o_cmd.scan_start = 1'b1;
            end
            ST_SCAN: o_cmd.scan_step = 1'b1;
            ST_DRAIN: begin
                o_cmd.emit       = !i_stat.pipe_busy && i_stat.out_free;
                o_cmd.emit_query = !i_stat.pipe_busy && i_stat.out_free;
            end
            default: ;
        endcase
    end

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result emitted while output register is occupied");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_stat.last_addr) |=> r_state == ST_DRAIN)
        else $error("scan did not stop at the last stored point");

endmodule

/* rtl/core/gbpm_dp.sv */
// Datapath of the match core: registers, point store, distance pipeline, result.
module gbpm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gbpm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  gbpm_pkg::t_req                    i_req,
    input  gbpm_pkg::t_dp_cmd                 i_cmd,
    input  logic                              i_out_ready,
    output gbpm_pkg::t_dp_stat                o_stat,
    output logic                              o_out_valid,
    output gbpm_pkg::t_rsp                    o_out
);
    import gbpm_pkg::*;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // configuration
    logic [GRID_CNT_W-1:0] r_grid_rows, r_grid_cols;
    logic [COORD_BITS-1:0] r_start_x, r_start_y, r_pitch_x, r_pitch_y, r_miss;

    // store and query setup
    logic [SQ_W-1:0]       mem [MAX_POINTS];
    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_addr;
    logic [GRID_IDX_W-1:0] r_row, r_col;
    logic [PROD_W-1:0]     r_prod_x, r_prod_y;
    logic [COORD_BITS-1:0] r_nom_x, r_nom_y;
    logic [SQ_W-1:0]       r_limit;

    // distance pipeline
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic [ADDR_W-1:0]     r_i1, r_i2, r_i3, r_i4;
    logic [SQ_W-1:0]       r_rdata;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]       r_sqx, r_sqy;
    logic [DIST_W-1:0]     r_sum;

    // running best
    logic                  r_best_valid;
    logic [DIST_W-1:0]     r_best;
    logic [ADDR_W-1:0]     r_best_i;

    logic                  r_out_valid;
    t_rsp                  r_out;
    t_rsp                  n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_CNT_W'(1);
            r_grid_cols <= GRID_CNT_W'(1);
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_pitch_x   <= '0;
            r_pitch_y   <= '0;
            r_miss      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_wdata[GRID_CNT_W-1:0];
                CFG_GRID_COLS: r_grid_cols <= i_cfg_wdata[GRID_CNT_W-1:0];
                CFG_START_X:   r_start_x   <= i_cfg_wdata;
                CFG_START_Y:   r_start_y   <= i_cfg_wdata;
                CFG_PITCH_X:   r_pitch_x   <= i_cfg_wdata;
                CFG_PITCH_Y:   r_pitch_y   <= i_cfg_wdata;
                CFG_MISS_DIST: r_miss      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // point store: write at the fill count, read at the scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[r_count[ADDR_W-1:0]] <= {i_req.point_x, i_req.point_y};
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_row <= i_req.grid_row;
            r_col <= i_req.grid_col;
        end
        if (i_cmd.mul) begin
            r_prod_x <= {{GRID_IDX_W{1'b0}}, r_pitch_x} * {{COORD_BITS{1'b0}}, r_col};
            r_prod_y <= {{GRID_IDX_W{1'b0}}, r_pitch_y} * {{COORD_BITS{1'b0}}, r_row};
            r_limit  <= {{COORD_BITS{1'b0}}, r_miss} * {{COORD_BITS{1'b0}}, r_miss};
        end
        if (i_cmd.add) begin
            r_nom_x <= sat_coord({{(NOM_W-COORD_BITS){1'b0}}, r_start_x} + {1'b0, r_prod_x});
            r_nom_y <= sat_coord({{(NOM_W-COORD_BITS){1'b0}}, r_start_y} + {1'b0, r_prod_y});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_i1  <= r_addr;
        r_dx  <= abs_diff(r_rdata[SQ_W-1:COORD_BITS], r_nom_x);
        r_dy  <= abs_diff(r_rdata[COORD_BITS-1:0], r_nom_y);
        r_i2  <= r_i1;
        r_sqx <= {{COORD_BITS{1'b0}}, r_dx} * {{COORD_BITS{1'b0}}, r_dx};
        r_sqy <= {{COORD_BITS{1'b0}}, r_dy} * {{COORD_BITS{1'b0}}, r_dy};
        r_i3  <= r_i2;
        r_sum <= sat_dist({1'b0, r_sqx} + {1'b0, r_sqy});
        r_i4  <= r_i3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // strict compare keeps the lowest index on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_best_valid <= 1'b0;
        end else if (r_v4 && (!r_best_valid || r_sum < r_best)) begin
            r_best_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && (!r_best_valid || r_sum < r_best)) begin
            r_best   <= r_sum;
            r_best_i <= r_i4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // form the result; fields other than status stay zero unless a query finishes
    always_comb begin
        n_out        = '0;
        n_out.status = i_cmd.status;
        if (i_cmd.emit_query) begin
            n_out.nominal_x       = r_nom_x;
            n_out.nominal_y       = r_nom_y;
            n_out.ball_present    = (DIST_W'(r_limit) >= r_best);
            n_out.nearest_dist_sq = r_best;
            n_out.nearest_index   = INDEX_W'(r_best_i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(MAX_POINTS));
    assign o_stat.outside   = ({1'b0, i_req.grid_row} >= r_grid_rows)
                           || ({1'b0, i_req.grid_col} >= r_grid_cols);
    assign o_stat.last_addr = ({1'b0, r_addr} == (r_count - CNT_W'(1)));
    assign o_stat.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("fill count beyond store depth");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_count != '0)
        else $error("load wrapped the fill count");

    a_best_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_query |-> r_best_valid)
        else $error("query result without any compared point");

endmodule

/* rtl/core/grid_ball_presence_match_core.sv */
// Top level of the grid ball presence match core.
//
// Requests arrive on i_req (valid/ready), results leave on o_rsp; each
// request except the unused command code gives exactly one result. Registers
// are written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must write
// them only while the core is idle, which the core itself does not enforce.
//
// Load and clear requests finish in the cycle they are taken; the result shows
// on o_rsp in the next cycle. A query on an empty store or outside the grid
// does the same. A normal query runs nominal setup (multiply, then add with
// saturation), then reads one stored point per cycle through the single read
// port of the point store, then drains the read/difference/square/sum/compare
// pipeline.
//
// Only one request is in work at a time. A finished result waits in the output
// register; a new request is taken while it waits if the receiver takes it in
// the same cycle, otherwise the core holds i_req.ready low. A query that
// finishes while the receiver stalls holds in its drain step until the output
// register frees. Synchronous reset empties the store (fill count to zero),
// restores the register defaults and drops any pending result; no clearing
// pass is needed.
module grid_ball_presence_match_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gbpm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gbpm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    gbpm_req_if.sink                         i_req,
    gbpm_rsp_if.source                       o_rsp
);
    import gbpm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     req_ready;
    logic     out_valid;
    t_rsp     out_data;

    // Sequencer: decode requests and step the query through setup and scan.
    gbpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_cmd   (i_req.payload.cmd),
        .i_stat      (dp_stat),
        .o_req_ready (req_ready),
        .o_cmd       (dp_cmd)
    );

    // Datapath: registers, point store, distance pipeline and result register.
    gbpm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req.payload),
        .i_cmd       (dp_cmd),
        .i_out_ready (o_rsp.ready),
        .o_stat      (dp_stat),
        .o_out_valid (out_valid),
        .o_out       (out_data)
    );

    assign i_req.ready   = req_ready;
    assign o_rsp.valid   = out_valid;
    assign o_rsp.payload = out_data;

endmodule
